FILE: sv/bdh_pkg.sv
// Package for the button debouncer with hold and auto-repeat.
// Holds the payload structs, the queue command and the shared codes and sizes.
// No dependencies.
package bdh_pkg;

	localparam int NUM_BUTTONS = 5;
	localparam int TIME_BITS   = 32;
	localparam int BIDX_W      = $clog2(NUM_BUTTONS);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int TAP_EXTRA   = 80;
	localparam int HOLD_EXTRA  = 200;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_TAP  = 2'd1;
	localparam logic [1:0] FUNC_HOLD = 2'd2;

	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_REPEAT  = 2'd2;
	localparam logic [1:0] KIND_HOLD    = 2'd3;

	localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [2:0] REG_HOLD_TIME    = 3'd1;
	localparam logic [2:0] REG_REPEAT_AFTER = 3'd2;
	localparam logic [2:0] REG_REPEAT_EVERY = 3'd3;
	localparam logic [2:0] REG_REPEAT_MASK  = 3'd4;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_VSET = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now;
		logic [4:0]  pins_low;
		logic [2:0]  button;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_button;
		logic [1:0] event_kind;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] debounce_time;
		logic [15:0] hold_time;
		logic [15:0] repeat_after;
		logic [15:0] repeat_every;
		logic [4:0]  repeat_mask;
	} cfg_t;

	// Decoded command: a tick carries now and pins, a virtual set carries the deadline
	typedef struct packed {
		logic                   op;
		logic [TIME_BITS-1:0]   tval;
		logic [NUM_BUTTONS-1:0] pins;
		logic [BIDX_W-1:0]      button;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: sv/button_debounce_hold_repeat.sv
// Top level of the button debouncer with hold and auto-repeat.
// Holds the configuration registers; uses bdh_pkg, bdh_front, bdh_queue, bdh_back.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  in      | in_valid / in_ready | in_data: func, now, pins_low, button
//  out     | out_valid/out_ready | out_data: event_button, event_kind, last
//  cfg     | cfg_we              | cfg_idx, cfg_wdata
//
// A tick runs through phases A and B for each button in turn in the back-end
// engine, then emits one event per cycle while the output is taken. Virtual
// taps and holds are applied in the idle state as they are popped.
// The two-deep command queue keeps taking input while events wait on the output.
// Reset restores the register defaults and clears the button flags at once; the per-button time stores are not reset.
module button_debounce_hold_repeat (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bdh_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bdh_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);
	import bdh_pkg::*;

	cfg_t      cfg_q;
	q_status_t q_stat;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= 16'd20;
			cfg_q.hold_time     <= 16'd1000;
			cfg_q.repeat_after  <= 16'd1000;
			cfg_q.repeat_every  <= 16'd100;
			cfg_q.repeat_mask   <= 5'd3;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEBOUNCE:     cfg_q.debounce_time <= cfg_wdata;
				REG_HOLD_TIME:    cfg_q.hold_time     <= cfg_wdata;
				REG_REPEAT_AFTER: cfg_q.repeat_after  <= cfg_wdata;
				REG_REPEAT_EVERY: cfg_q.repeat_every  <= cfg_wdata;
				REG_REPEAT_MASK:  cfg_q.repeat_mask   <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	bdh_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	bdh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	bdh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: sv/bdh_front.sv
// Front end: takes input transactions, drops unused codes and out-of-range buttons,
// and turns the rest into queue commands, working out virtual deadlines. Uses bdh_pkg.
module bdh_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  bdh_pkg::in_item_t in_data,
	input  bdh_pkg::cfg_t     cfg,
	input  bdh_pkg::q_status_t q_stat,
	output logic              push,
	output bdh_pkg::cmd_t     push_cmd
);
	import bdh_pkg::*;

	logic                 btn_ok;
	logic                 is_tick;
	logic                 is_vset;
	logic [TIME_BITS-1:0] now_t;
	logic [16:0]          hold_extra;
	logic [TIME_BITS-1:0] extra;

	assign in_ready   = !q_stat.full;
	assign now_t      = in_data.now[TIME_BITS-1:0];
	assign btn_ok     = in_data.button < 3'(NUM_BUTTONS);
	assign is_tick    = in_data.func == FUNC_TICK;
	assign is_vset    = (in_data.func == FUNC_TAP || in_data.func == FUNC_HOLD) && btn_ok;
	assign hold_extra = {1'b0, cfg.hold_time} + 17'(HOLD_EXTRA);
	assign extra      = (in_data.func == FUNC_TAP) ? TIME_BITS'(TAP_EXTRA)
	                                               : TIME_BITS'(hold_extra);

	// Unused func codes and bad indices are accepted and dropped here
	assign push = in_valid && in_ready && (is_tick || is_vset);

	always_comb begin
		push_cmd.op     = is_tick ? OP_TICK : OP_VSET;
		push_cmd.tval   = is_tick ? now_t : now_t + extra;
		push_cmd.pins   = NUM_BUTTONS'(in_data.pins_low);
		push_cmd.button = in_data.button[BIDX_W-1:0];
	end

endmodule

FILE: sv/bdh_queue.sv
// Short command queue between front and back end.
// Register array with read and write pointers. Uses bdh_pkg.
module bdh_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bdh_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output bdh_pkg::cmd_t      head,
	output bdh_pkg::q_status_t q_stat
);
	import bdh_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head         = mem_q[rptr_q];
	assign q_stat.full  = cnt_q == QCNT_W'(QDEPTH);
	assign q_stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/bdh_back.sv
// Back end: per-button debounce, hold and repeat engine, one button at a time in phases A and B,
// then serial event emission through the output register. Uses bdh_pkg.
module bdh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bdh_pkg::cfg_t      cfg,
	input  bdh_pkg::cmd_t      head,
	input  bdh_pkg::q_status_t q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output bdh_pkg::out_item_t out_data
);
	import bdh_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PA   = 2'd1;
	localparam logic [1:0] ST_PB   = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                  state_q;
	logic [BIDX_W-1:0]           cnt_q;
	logic [TIME_BITS-1:0]        now_q;
	logic [NUM_BUTTONS-1:0]      pins_q;

	logic [NUM_BUTTONS-1:0]      raw_q;
	logic [NUM_BUTTONS-1:0]      stable_q;
	logic [NUM_BUTTONS-1:0]      hold_sent_q;
	logic [NUM_BUTTONS-1:0]      vact_q;
	logic [TIME_BITS-1:0]        last_edge_q [NUM_BUTTONS];
	logic [TIME_BITS-1:0]        press_q     [NUM_BUTTONS];
	logic [TIME_BITS-1:0]        last_rep_q  [NUM_BUTTONS];
	logic [TIME_BITS-1:0]        vuntil_q    [NUM_BUTTONS];

	// Pending events of this tick: edge, repeat, hold per button
	logic [NUM_BUTTONS-1:0][2:0] ev_q;
	logic [NUM_BUTTONS-1:0]      edge_press_q;

	logic      out_valid_q;
	out_item_t out_q;

	// Phase A
	logic [TIME_BITS-1:0] vdiff;
	logic                 vheld;
	logic                 raw_new;

	// Phase B
	logic [TIME_BITS-1:0] edge_age;
	logic [TIME_BITS-1:0] held;
	logic [TIME_BITS-1:0] rep_age;
	logic                 chg;
	logic                 new_press;
	logic                 stable_new;
	logic                 rep_cond;
	logic                 rep_fire;
	logic                 hold_fire;

	// Emission
	logic [BIDX_W-1:0]           sel_b;
	logic [1:0]                  sel_s;
	logic [NUM_BUTTONS-1:0][2:0] ev_clr;
	logic                        ev_last;
	logic                        slot_free;
	logic                        load;
	logic [1:0]                  sel_kind;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign slot_free = !out_valid_q || out_ready;
	assign load      = (state_q == ST_EMIT) && (ev_q != '0) && slot_free;

	assign vdiff   = now_q - vuntil_q[cnt_q];
	assign vheld   = vact_q[cnt_q] && vdiff[TIME_BITS-1];
	assign raw_new = pins_q[cnt_q] || vheld;

	always_comb begin
		edge_age   = now_q - last_edge_q[cnt_q];
		held       = now_q - press_q[cnt_q];
		rep_age    = now_q - last_rep_q[cnt_q];
		chg        = (raw_q[cnt_q] != stable_q[cnt_q]) &&
		             (edge_age >= TIME_BITS'(cfg.debounce_time));
		new_press  = chg && raw_q[cnt_q];
		stable_new = chg ? raw_q[cnt_q] : stable_q[cnt_q];
		// A fresh press has zero held time and zero time since the last repeat
		if (new_press) begin
			rep_cond  = (cfg.repeat_after == '0) && (cfg.repeat_every == '0);
			hold_fire = cfg.hold_time == '0;
		end else begin
			rep_cond  = (held >= TIME_BITS'(cfg.repeat_after)) &&
			            (rep_age >= TIME_BITS'(cfg.repeat_every));
			hold_fire = stable_new && !hold_sent_q[cnt_q] &&
			            (held >= TIME_BITS'(cfg.hold_time));
		end
		rep_fire = stable_new && cfg.repeat_mask[cnt_q] && rep_cond;
	end

	// Lowest pending event wins
	always_comb begin
		sel_b = '0;
		sel_s = '0;
		for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
			for (int s = 2; s >= 0; s--) begin
				if (ev_q[b][s]) begin
					sel_b = BIDX_W'(b);
					sel_s = 2'(s);
				end
			end
		end
		ev_clr               = ev_q;
		ev_clr[sel_b][sel_s] = 1'b0;
		ev_last              = ev_clr == '0;
		unique case (sel_s)
			2'd0:    sel_kind = edge_press_q[sel_b] ? KIND_PRESS : KIND_RELEASE;
			2'd1:    sel_kind = KIND_REPEAT;
			default: sel_kind = KIND_HOLD;
		endcase
	end

	// Per-button time stores: read only after written, so no reset
	always_ff @(posedge clk) begin
		if (pop && head.op == OP_TICK) begin
			now_q  <= head.tval;
			pins_q <= head.pins;
		end
		if (pop && head.op == OP_VSET) begin
			vuntil_q[head.button] <= head.tval;
		end
		if (state_q == ST_PA && raw_new != raw_q[cnt_q]) begin
			last_edge_q[cnt_q] <= now_q;
		end
		if (state_q == ST_PB) begin
			if (new_press || rep_fire) begin
				last_rep_q[cnt_q] <= now_q;
			end
			if (new_press) begin
				press_q[cnt_q] <= now_q;
			end
		end
		if (load) begin
			out_q.event_button <= 3'(sel_b);
			out_q.event_kind   <= sel_kind;
			out_q.last         <= ev_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			raw_q        <= '0;
			stable_q     <= '0;
			hold_sent_q  <= '0;
			vact_q       <= '0;
			ev_q         <= '0;
			edge_press_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.op == OP_VSET) begin
							vact_q[head.button] <= 1'b1;
						end else begin
							cnt_q   <= '0;
							ev_q    <= '0;
							state_q <= ST_PA;
						end
					end
				end
				ST_PA: begin
					// Drop an expired virtual deadline
					if (vact_q[cnt_q] && !vheld) begin
						vact_q[cnt_q] <= 1'b0;
					end
					raw_q[cnt_q] <= raw_new;
					state_q      <= ST_PB;
				end
				ST_PB: begin
					stable_q[cnt_q]     <= stable_new;
					ev_q[cnt_q]         <= {hold_fire, rep_fire, chg};
					edge_press_q[cnt_q] <= raw_q[cnt_q];
					if (hold_fire) begin
						hold_sent_q[cnt_q] <= 1'b1;
					end else if (new_press) begin
						hold_sent_q[cnt_q] <= 1'b0;
					end
					if (cnt_q == BIDX_W'(NUM_BUTTONS - 1)) begin
						state_q <= ST_EMIT;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_PA;
					end
				end
				ST_EMIT: begin
					if (ev_q == '0) begin
						state_q <= ST_IDLE;
					end else if (load) begin
						ev_q <= ev_clr;
						if (ev_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

endmodule

FILE: sv/bdh_checker.sv
// Port-level checker for the button debouncer, bound to the top level.
// Uses bdh_pkg.
module bdh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input bdh_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input bdh_pkg::out_item_t out_data
);
	import bdh_pkg::*;

	logic out_xfer;
	assign out_xfer = out_valid && out_ready;

	// Stalled input transaction holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input changed while stalled");

	// Stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// Events of one tick follow back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !out_data.last |=> out_valid)
		else $error("gap inside an event burst");

	// Within a tick, buttons come in rising order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !out_data.last |=>
			out_data.event_button >= $past(out_data.event_button))
		else $error("events out of button order");

	// Nothing else for a button follows its release in the same tick
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !out_data.last && out_data.event_kind == KIND_RELEASE |=>
			out_data.event_button != $past(out_data.event_button))
		else $error("event after release of the same button");

endmodule

bind button_debounce_hold_repeat bdh_checker u_bdh_checker (.*);
